FILE: src/cesd_pkg.sv
package cesd_pkg;

  typedef logic [7:0] byte_t;

  // escape decoder modes
  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX0  = 2'd2,
    MODE_HEX1  = 2'd3
  } mode_t;

  localparam byte_t CH_BSL  = 8'h5C;
  localparam byte_t CH_NL   = 8'h0A;
  localparam byte_t CH_CR   = 8'h0D;
  localparam byte_t CH_VT   = 8'h0B;
  localparam byte_t CH_BS   = 8'h08;
  localparam byte_t CH_N    = 8'h6E;
  localparam byte_t CH_R    = 8'h72;
  localparam byte_t CH_V    = 8'h76;
  localparam byte_t CH_B    = 8'h62;
  localparam byte_t CH_X    = 8'h78;
  localparam byte_t CH_ZERO = 8'h30;
  localparam byte_t CH_NINE = 8'h39;
  localparam byte_t CH_LA   = 8'h61;
  localparam byte_t CH_LF   = 8'h66;
  localparam byte_t CH_UA   = 8'h41;
  localparam byte_t CH_UF   = 8'h46;
  localparam byte_t CH_NUL  = 8'h00;

  localparam int MaxOut = 4;
  localparam int CntW   = $clog2(MaxOut + 1);
  localparam int PosW   = $clog2(MaxOut);

  typedef logic [CntW-1:0] cnt_t;
  typedef logic [PosW-1:0] pos_t;

  // decoded hex digit
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
    logic       upper;
  } hex_t;

  // list of bytes produced by one input beat
  typedef struct packed {
    byte_t [MaxOut-1:0] bytes;
    cnt_t               cnt;
  } emit_t;

  function automatic hex_t hex_decode(byte_t b);
    hex_t h;
    h = '0;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      h.ok  = 1'b1;
      h.val = 4'(b - CH_ZERO);
    end else if (b >= CH_LA && b <= CH_LF) begin
      h.ok  = 1'b1;
      h.val = 4'(b - CH_LA + 8'd10);
    end else if (b >= CH_UA && b <= CH_UF) begin
      h.ok    = 1'b1;
      h.val   = 4'(b - CH_UA + 8'd10);
      h.upper = 1'b1;
    end
    return h;
  endfunction

  // held digit back to its original character
  function automatic byte_t held_char(logic [3:0] v, logic upper);
    byte_t r;
    if (v < 4'd10) begin
      r = CH_ZERO + {4'h0, v};
    end else begin
      r = (upper ? CH_UA : CH_LA) + {4'h0, v} - 8'd10;
    end
    return r;
  endfunction

  // append one byte to the list
  function automatic emit_t push(emit_t e, byte_t b);
    emit_t r;
    r = e;
    if (e.cnt < cnt_t'(MaxOut)) begin
      r.bytes[e.cnt[PosW-1:0]] = b;
      r.cnt = e.cnt + cnt_t'(1);
    end
    return r;
  endfunction

endpackage

FILE: src/cesd_in_if.sv
interface cesd_in_if;
  logic           valid;
  logic           ready;
  cesd_pkg::byte_t in_byte;
  logic           end_of_text;

  modport source (output valid, in_byte, end_of_text, input ready);
  modport sink   (input valid, in_byte, end_of_text, output ready);
endinterface

FILE: src/cesd_out_if.sv
interface cesd_out_if;
  logic           valid;
  logic           ready;
  cesd_pkg::byte_t out_byte;
  logic           run_last;
  logic           text_done;

  modport source (output valid, out_byte, run_last, text_done, input ready);
  modport sink   (input valid, out_byte, run_last, text_done, output ready);
endinterface

FILE: src/c_escape_string_decoder_unit.sv
// channel | dir | payload                          | handshake
// in_ch   | in  | in_byte[8], end_of_text          | valid/ready
// out_ch  | out | out_byte[8], run_last, text_done | valid/ready
//
// Each input beat is decoded in the cycle it is accepted into a result
// buffer of up to four bytes, which drains one beat per cycle while out_ch is ready.
// A beat with one result (or none) keeps one input per cycle while out_ch is ready;
// a beat with more results holds input until they drain through the single output port.
// Input is taken while the last buffered byte leaves in the same cycle.
// rst_n is synchronous, active low; it clears decoder mode and the buffer.
module c_escape_string_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  cesd_in_if.sink    in_ch,
  cesd_out_if.source out_ch
);

  cesd_pkg::mode_t mode_r, mode_nxt;
  logic [3:0]      digit_r, digit_nxt;
  logic            upper_r, upper_nxt;

  cesd_pkg::byte_t [cesd_pkg::MaxOut-1:0] buf_r;
  cesd_pkg::cnt_t  rem_r;
  cesd_pkg::pos_t  pos_r;
  logic            last_r;

  cesd_pkg::emit_t e;
  cesd_pkg::hex_t  hx;
  cesd_pkg::byte_t b;
  logic            in_fire;
  logic            out_fire;

  assign b        = in_ch.in_byte;
  assign hx       = cesd_pkg::hex_decode(b);
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_fire  = in_ch.valid && in_ch.ready;

  // take a new beat when the buffer is empty or emptying now
  assign in_ch.ready = (rem_r == '0) ||
                       (rem_r == cesd_pkg::cnt_t'(1) && out_ch.ready);

  // decode one input byte against the current escape mode
  always_comb begin
    mode_nxt  = mode_r;
    digit_nxt = digit_r;
    upper_nxt = upper_r;
    e         = '0;
    case (mode_r)
      cesd_pkg::MODE_PLAIN: begin
        if (b == cesd_pkg::CH_BSL) mode_nxt = cesd_pkg::MODE_ESC;
        else e = cesd_pkg::push(e, b);
      end
      cesd_pkg::MODE_ESC: begin
        mode_nxt = cesd_pkg::MODE_PLAIN;
        if (b == cesd_pkg::CH_BSL) begin
          e = cesd_pkg::push(e, cesd_pkg::CH_BSL);
        end else if (b == cesd_pkg::CH_N) begin
          e = cesd_pkg::push(e, cesd_pkg::CH_NL);
        end else if (b == cesd_pkg::CH_R) begin
          e = cesd_pkg::push(e, cesd_pkg::CH_CR);
        end else if (b == cesd_pkg::CH_V) begin
          e = cesd_pkg::push(e, cesd_pkg::CH_VT);
        end else if (b == cesd_pkg::CH_B) begin
          e = cesd_pkg::push(e, cesd_pkg::CH_BS);
        end else if (b == cesd_pkg::CH_ZERO) begin
          e = cesd_pkg::push(e, cesd_pkg::CH_BSL);
          e = cesd_pkg::push(e, cesd_pkg::CH_NUL);
        end else if (b == cesd_pkg::CH_X) begin
          mode_nxt = cesd_pkg::MODE_HEX0;
        end else begin
          e = cesd_pkg::push(e, cesd_pkg::CH_BSL);
          e = cesd_pkg::push(e, b);
        end
      end
      cesd_pkg::MODE_HEX0: begin
        if (hx.ok) begin
          digit_nxt = hx.val;
          upper_nxt = hx.upper;
          mode_nxt  = cesd_pkg::MODE_HEX1;
        end else begin
          mode_nxt = cesd_pkg::MODE_PLAIN;
          e = cesd_pkg::push(e, cesd_pkg::CH_BSL);
          e = cesd_pkg::push(e, cesd_pkg::CH_X);
          if (b == cesd_pkg::CH_BSL) mode_nxt = cesd_pkg::MODE_ESC;
          else e = cesd_pkg::push(e, b);
        end
      end
      default: begin
        mode_nxt = cesd_pkg::MODE_PLAIN;
        if (hx.ok) begin
          // a value of zero comes out as backslash, zero byte
          if (digit_r == 4'h0 && hx.val == 4'h0) begin
            e = cesd_pkg::push(e, cesd_pkg::CH_BSL);
            e = cesd_pkg::push(e, cesd_pkg::CH_NUL);
          end else begin
            e = cesd_pkg::push(e, {digit_r, hx.val});
          end
        end else begin
          e = cesd_pkg::push(e, cesd_pkg::CH_BSL);
          e = cesd_pkg::push(e, cesd_pkg::CH_X);
          e = cesd_pkg::push(e, cesd_pkg::held_char(digit_r, upper_r));
          if (b == cesd_pkg::CH_BSL) mode_nxt = cesd_pkg::MODE_ESC;
          else e = cesd_pkg::push(e, b);
        end
        digit_nxt = 4'h0;
        upper_nxt = 1'b0;
      end
    endcase

    // flush an unfinished escape at end of text
    if (in_ch.end_of_text) begin
      if (mode_nxt != cesd_pkg::MODE_PLAIN) e = cesd_pkg::push(e, cesd_pkg::CH_BSL);
      if (mode_nxt == cesd_pkg::MODE_HEX0 || mode_nxt == cesd_pkg::MODE_HEX1) begin
        e = cesd_pkg::push(e, cesd_pkg::CH_X);
      end
      if (mode_nxt == cesd_pkg::MODE_HEX1) begin
        e = cesd_pkg::push(e, cesd_pkg::held_char(digit_nxt, upper_nxt));
      end
      mode_nxt  = cesd_pkg::MODE_PLAIN;
      digit_nxt = 4'h0;
      upper_nxt = 1'b0;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= cesd_pkg::MODE_PLAIN;
      digit_r <= 4'h0;
      upper_r <= 1'b0;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      digit_r <= digit_nxt;
      upper_r <= upper_nxt;
    end
  end

  // result buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      pos_r <= '0;
    end else if (in_fire) begin
      rem_r <= e.cnt;
      pos_r <= '0;
    end else if (out_fire) begin
      rem_r <= rem_r - cesd_pkg::cnt_t'(1);
      pos_r <= pos_r + cesd_pkg::pos_t'(1);
    end
  end

  // result buffer payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      buf_r  <= e.bytes;
      last_r <= in_ch.end_of_text;
    end
  end

  // output beat
  assign out_ch.valid     = (rem_r != '0);
  assign out_ch.out_byte  = buf_r[pos_r];
  assign out_ch.run_last  = (rem_r == cesd_pkg::cnt_t'(1));
  assign out_ch.text_done = (rem_r == cesd_pkg::cnt_t'(1)) && last_r;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cesd_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int LongHold   = 150;
  localparam int TailCycles = 8;

  // one decoded output beat
  typedef struct packed {
    byte_t data;
    logic  run_last;
    logic  text_done;
  } decoded_t;

  logic clk;
  logic rst_n;

  cesd_in_if  in_ch ();
  cesd_out_if out_ch ();

  c_escape_string_decoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow decoder state
  mode_t      esc_mode   = MODE_PLAIN;
  logic [3:0] held_digit = 4'h0;
  logic       held_up    = 1'b0;
  byte_t      step_bytes[$];

  decoded_t pending_decoded[$];
  byte_t    text_q[$];
  int       mismatches  = 0;
  int       beats_sent  = 0;
  int       cycle_count = 0;
  int       in_gap_pct  = 0;
  int       out_gap_pct = 0;
  bit       hold_output = 1'b0;

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // -1 when not a hex digit
  function automatic int hex_weight(byte_t b);
    if (b >= CH_ZERO && b <= CH_NINE) return int'(b - CH_ZERO);
    if (b >= CH_LA && b <= CH_LF) return int'(b - CH_LA) + 10;
    if (b >= CH_UA && b <= CH_UF) return int'(b - CH_UA) + 10;
    return -1;
  endfunction

  // rebuild the character of a held digit, keeping its case
  function automatic byte_t digit_char(logic [3:0] v, logic up);
    if (v < 4'd10) return CH_ZERO + byte_t'(v);
    if (up) return CH_UA + byte_t'(v - 4'd10);
    return CH_LA + byte_t'(v - 4'd10);
  endfunction

  function automatic void put_byte(byte_t b);
    if (step_bytes.size() < MaxOut) step_bytes.push_back(b);
  endfunction

  function automatic void plain_char(byte_t b);
    if (b == CH_BSL) esc_mode = MODE_ESC;
    else put_byte(b);
  endfunction

  // advance the shadow decoder by one input beat and queue its output
  function automatic void decode_beat(byte_t b, logic eot);
    int       h;
    byte_t    v;
    decoded_t r;
    step_bytes.delete();
    h = hex_weight(b);
    case (esc_mode)
      MODE_PLAIN: plain_char(b);
      MODE_ESC: begin
        esc_mode = MODE_PLAIN;
        case (b)
          CH_BSL:  put_byte(CH_BSL);
          CH_N:    put_byte(CH_NL);
          CH_R:    put_byte(CH_CR);
          CH_V:    put_byte(CH_VT);
          CH_B:    put_byte(CH_BS);
          CH_ZERO: begin
            put_byte(CH_BSL);
            put_byte(CH_NUL);
          end
          CH_X:    esc_mode = MODE_HEX0;
          default: begin
            put_byte(CH_BSL);
            put_byte(b);
          end
        endcase
      end
      MODE_HEX0: begin
        if (h >= 0) begin
          held_digit = h[3:0];
          held_up    = (b >= CH_UA && b <= CH_UF);
          esc_mode   = MODE_HEX1;
        end else begin
          esc_mode = MODE_PLAIN;
          put_byte(CH_BSL);
          put_byte(CH_X);
          plain_char(b);
        end
      end
      default: begin
        esc_mode = MODE_PLAIN;
        if (h >= 0) begin
          v = {held_digit, h[3:0]};
          if (v == CH_NUL) begin
            put_byte(CH_BSL);
            put_byte(CH_NUL);
          end else begin
            put_byte(v);
          end
        end else begin
          put_byte(CH_BSL);
          put_byte(CH_X);
          put_byte(digit_char(held_digit, held_up));
          plain_char(b);
        end
        held_digit = 4'h0;
        held_up    = 1'b0;
      end
    endcase
    // flush an unfinished escape at end of text
    if (eot) begin
      if (esc_mode != MODE_PLAIN) put_byte(CH_BSL);
      if (esc_mode == MODE_HEX0 || esc_mode == MODE_HEX1) put_byte(CH_X);
      if (esc_mode == MODE_HEX1) put_byte(digit_char(held_digit, held_up));
      esc_mode   = MODE_PLAIN;
      held_digit = 4'h0;
      held_up    = 1'b0;
    end
    foreach (step_bytes[i]) begin
      r.data      = step_bytes[i];
      r.run_last  = (i == step_bytes.size() - 1);
      r.text_done = eot && r.run_last;
      pending_decoded.push_back(r);
    end
  endfunction

  // output side ready: random stall bursts plus the long hold-off
  initial begin : output_sink
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
        hold_output = 1'b0;
        out_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 99) < out_gap_pct) begin
        n = $urandom_range(1, 16);
        out_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // compare every output beat with the oldest expected byte
  always @(posedge clk) begin : check_output
    decoded_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_decoded.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual byte %02h last %0b done %0b",
                 $time, out_ch.out_byte, out_ch.run_last, out_ch.text_done);
        mismatches++;
      end else begin
        want = pending_decoded.pop_front();
        if (out_ch.out_byte !== want.data) begin
          $display("%0t: out_byte expected %02h actual %02h",
                   $time, want.data, out_ch.out_byte);
          mismatches++;
        end
        if (out_ch.run_last !== want.run_last) begin
          $display("%0t: run_last expected %0b actual %0b",
                   $time, want.run_last, out_ch.run_last);
          mismatches++;
        end
        if (out_ch.text_done !== want.text_done) begin
          $display("%0t: text_done expected %0b actual %0b",
                   $time, want.text_done, out_ch.text_done);
          mismatches++;
        end
      end
    end
  end

  // offer one input beat and wait for it to be taken
  task automatic send_beat(byte_t b, logic eot);
    int gap;
    @(negedge clk);
    if ($urandom_range(0, 99) < in_gap_pct) begin
      gap = $urandom_range(1, 16);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.in_byte     <= b;
    in_ch.end_of_text <= eot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_beat(b, eot);
    beats_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_beat(text_q[i], i == text_q.size() - 1);
  endtask

  // stop offering input until every expected byte is out
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_decoded.size() != 0) @(posedge clk);
  endtask

  function automatic byte_t rand_plain();
    byte_t b;
    do b = byte_t'($urandom_range(1, 255)); while (b == CH_BSL);
    return b;
  endfunction

  function automatic byte_t rand_hex();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) return CH_ZERO + byte_t'(k);
    if (k < 16) return CH_LA + byte_t'(k - 10);
    return CH_UA + byte_t'(k - 16);
  endfunction

  // random text: plain bytes, well-formed escapes, broken ones and noise
  function automatic void build_text();
    int    tokens;
    byte_t ctl[5];
    ctl    = '{CH_BSL, CH_N, CH_R, CH_V, CH_B};
    tokens = $urandom_range(1, 8);
    text_q.delete();
    repeat (tokens) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3: text_q.push_back(rand_plain());
        4: begin
          text_q.push_back(CH_BSL);
          text_q.push_back(ctl[$urandom_range(0, 4)]);
        end
        5: begin
          text_q.push_back(CH_BSL);
          text_q.push_back(CH_ZERO);
        end
        6, 7: begin
          text_q.push_back(CH_BSL);
          text_q.push_back(CH_X);
          text_q.push_back(rand_hex());
          text_q.push_back(rand_hex());
        end
        8: begin
          text_q.push_back(CH_BSL);
          text_q.push_back(CH_X);
          text_q.push_back(rand_hex());
          text_q.push_back(byte_t'($urandom_range(1, 255)));
        end
        9: begin
          text_q.push_back(CH_BSL);
          text_q.push_back(byte_t'($urandom_range(1, 255)));
        end
        10: begin
          text_q.push_back(CH_BSL);
          text_q.push_back(CH_X);
          text_q.push_back(byte_t'($urandom_range(1, 255)));
        end
        default: text_q.push_back(CH_BSL);
      endcase
    end
  endfunction

  // newline, return, vertical tab, backspace and backslash escapes
  task automatic test_control_escapes();
    text_q = {CH_BSL, CH_N, CH_BSL, CH_R, CH_BSL, CH_V, CH_BSL, CH_B, CH_BSL, CH_BSL};
    send_text();
  endtask

  // both spellings of the zero byte
  task automatic test_nul_escapes();
    text_q = {CH_BSL, CH_ZERO, CH_BSL, CH_X, CH_ZERO, CH_ZERO};
    send_text();
  endtask

  // unknown escape, hex escape without digits, lowest plain byte
  task automatic test_literal_passthrough();
    text_q = {CH_BSL, 8'hFF, CH_BSL, CH_X, 8'h67, 8'h01};
    send_text();
  endtask

  // escapes left open by the end of text
  task automatic test_end_of_text_flush();
    text_q = {CH_BSL, CH_X, CH_UA, CH_BSL};
    send_text();
    text_q = {CH_BSL};
    send_text();
    text_q = {CH_BSL, CH_X};
    send_text();
    text_q = {CH_BSL, CH_X, CH_LF};
    send_text();
  endtask

  // receiver stalls long while four-byte expansions keep coming
  task automatic test_output_backpressure();
    in_gap_pct  = 0;
    out_gap_pct = 0;
    hold_output = 1'b1;
    text_q.delete();
    repeat (5) begin
      text_q.push_back(CH_BSL);
      text_q.push_back(CH_X);
      text_q.push_back(CH_UF);
      text_q.push_back(8'h21);
    end
    send_text();
    wait_drained();
  endtask

  task automatic test_random_texts(int beat_goal, bit with_gaps);
    int goal;
    goal = beats_sent + beat_goal;
    while (beats_sent < goal) begin
      in_gap_pct  = with_gaps ? 20 * $urandom_range(0, 2) : 0;
      out_gap_pct = with_gaps ? 20 * $urandom_range(0, 2) : 0;
      build_text();
      send_text();
      if (with_gaps && $urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  initial begin : run_tests
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.in_byte     = 8'h00;
    in_ch.end_of_text = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    in_gap_pct  = 20;
    out_gap_pct = 20;
    test_control_escapes();
    test_nul_escapes();
    test_literal_passthrough();
    test_end_of_text_flush();
    wait_drained();
    test_output_backpressure();
    test_random_texts(90, 1'b1);
    test_random_texts(25, 1'b0);

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0 && pending_decoded.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: c_escape_string_decoder_unit.f
src/cesd_pkg.sv
src/cesd_in_if.sv
src/cesd_out_if.sv
src/c_escape_string_decoder_unit.sv
tb/testbench.sv
